@@ rtl/dts_pkg.sv @@
// Shared types and constants of the DSL token scanner.
package dts_pkg;

	// Default width of the line and column counters.
	localparam int unsigned POSITION_BITS_DEFAULT = 16;

	// Result kinds.
	localparam logic [4:0] KIND_IDENT  = 5'd0;
	localparam logic [4:0] KIND_BOOL   = 5'd1;
	localparam logic [4:0] KIND_NULL   = 5'd2;
	localparam logic [4:0] KIND_STRING = 5'd3;
	localparam logic [4:0] KIND_NUMBER = 5'd4;
	localparam logic [4:0] KIND_PIPE   = 5'd5;
	localparam logic [4:0] KIND_PUNCT0 = 5'd6;
	localparam logic [4:0] KIND_EOF    = 5'd17;

	// Error codes.
	localparam logic [1:0] ERR_NONE     = 2'd0;
	localparam logic [1:0] ERR_UNKNOWN  = 2'd1;
	localparam logic [1:0] ERR_UNTERMIN = 2'd2;

	// Characters with a special meaning.
	localparam logic [7:0] CH_HASH    = "#";
	localparam logic [7:0] CH_BAR     = "|";
	localparam logic [7:0] CH_GT      = ">";
	localparam logic [7:0] CH_DASH    = "-";
	localparam logic [7:0] CH_USCORE  = "_";
	localparam logic [7:0] CH_DQUOTE  = "\"";
	localparam logic [7:0] CH_SQUOTE  = "'";
	localparam logic [7:0] CH_BSLASH  = "\\";
	localparam logic [7:0] CH_NEWLINE = 8'h0a;
	localparam logic [7:0] CH_SPACE   = " ";
	localparam logic [7:0] CH_NUL     = 8'h00;

	// Keyword spellings, first letter in the highest byte of the spelling; a shorter word has a zero top byte.
	localparam logic [39:0] KW_TEXT_TRUE  = {8'h00, "TRUE"};
	localparam logic [39:0] KW_TEXT_FALSE = "FALSE";
	localparam logic [39:0] KW_TEXT_NULL  = {8'h00, "NULL"};

	// One input transaction.
	typedef struct packed {
		logic [7:0] char_byte;
		logic       end_of_input;
	} in_item_t;

	// One result transaction.
	typedef struct packed {
		logic [4:0]  token_kind;
		logic [7:0]  content_byte;
		logic        content_valid;
		logic        token_done;
		logic [15:0] start_line;
		logic [15:0] start_column;
		logic [1:0]  error_code;
		logic        last_of_run;
	} result_t;

	// All results of one input transaction, in order, with their count.
	typedef struct packed {
		result_t [2:0] res;
		logic [1:0]    count;
	} res_bundle_t;

endpackage

@@ rtl/dts_stream_if.sv @@
// Valid/ready stream channel used for the scanner's input and output.
interface dts_stream_if #(parameter type payload_t = logic) ();
	logic     valid;
	logic     ready;
	payload_t payload;

	modport source(output valid, output payload, input ready);
	modport sink(input valid, input payload, output ready);
endinterface

@@ rtl/dts_scan_core.sv @@
// Scanner state and the per-byte tokenizing logic that yields up to three results.
module dts_scan_core import dts_pkg::*; #(
	parameter int unsigned POSITION_BITS = POSITION_BITS_DEFAULT
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        fire,
	input  in_item_t    item,
	output res_bundle_t bundle
);

	typedef enum logic [2:0] {
		M_IDLE, M_IDENT, M_NUMBER, M_STRING, M_ESCAPE, M_PIPE, M_COMMENT
	} mode_t;

	typedef logic [POSITION_BITS-1:0] pos_t;

	localparam logic [1:0] KW_NONE  = 2'd0;
	localparam logic [1:0] KW_TRUE  = 2'd1;
	localparam logic [1:0] KW_FALSE = 2'd2;
	localparam logic [1:0] KW_NULL  = 2'd3;

	mode_t      mode_q, mode_d;
	logic       quote_single_q, quote_single_d;
	logic [1:0] kw_word_q, kw_word_d;
	logic [2:0] kw_pos_q, kw_pos_d;
	pos_t       line_q, line_d;
	pos_t       col_q, col_d;
	pos_t       tok_line_q, tok_line_d;
	pos_t       tok_col_q, tok_col_d;

	result_t [2:0] res;
	logic [1:0]    n;
	logic          go_idle;
	logic          do_str;
	logic          eoi;
	logic [7:0]    b;
	logic [7:0]    quote;
	logic [4:0]    pk;

	// Truncate or extend a position counter to the 16-bit result field.
	function automatic logic [15:0] pos16(input pos_t p);
		logic [POSITION_BITS+15:0] wide;
		wide = {16'd0, p};
		return wide[15:0];
	endfunction

	function automatic result_t make_res(input logic [4:0] kind, input logic [7:0] cb,
			input logic cv, input logic dn, input pos_t ln, input pos_t cl,
			input logic [1:0] err);
		result_t r;
		r.token_kind    = kind;
		r.content_byte  = cb;
		r.content_valid = cv;
		r.token_done    = dn;
		r.start_line    = pos16(ln);
		r.start_column  = pos16(cl);
		r.error_code    = err;
		r.last_of_run   = 1'b0;
		return r;
	endfunction

	function automatic logic [2:0] kw_length(input logic [1:0] w);
		case (w)
			KW_TRUE:  return 3'd4;
			KW_FALSE: return 3'd5;
			KW_NULL:  return 3'd4;
			default:  return 3'd0;
		endcase
	endfunction

	// True when byte c continues keyword w at letter position p.
	function automatic logic kw_next_ok(input logic [1:0] w, input logic [2:0] p,
			input logic [7:0] c);
		logic [39:0] text;
		logic [2:0]  len;
		logic [2:0]  idx;
		len = kw_length(w);
		case (w)
			KW_TRUE:  text = KW_TEXT_TRUE;
			KW_FALSE: text = KW_TEXT_FALSE;
			KW_NULL:  text = KW_TEXT_NULL;
			default:  text = '0;
		endcase
		idx = 3'(len - 3'd1 - p);
		if (w == KW_NONE || p >= len) begin
			return 1'b0;
		end
		return text[{idx, 3'b000} +: 8] == c;
	endfunction

	function automatic logic [4:0] ident_kind(input logic [1:0] w, input logic [2:0] p);
		if (w == KW_NONE || p != kw_length(w)) begin
			return KIND_IDENT;
		end
		return (w == KW_NULL) ? KIND_NULL : KIND_BOOL;
	endfunction

	// Kind of a single-character punctuation mark, or identifier kind if none.
	function automatic logic [4:0] punct_kind(input logic [7:0] c);
		case (c)
			"(":     return KIND_PUNCT0 + 5'd0;
			")":     return KIND_PUNCT0 + 5'd1;
			"{":     return KIND_PUNCT0 + 5'd2;
			"}":     return KIND_PUNCT0 + 5'd3;
			"[":     return KIND_PUNCT0 + 5'd4;
			"]":     return KIND_PUNCT0 + 5'd5;
			",":     return KIND_PUNCT0 + 5'd6;
			".":     return KIND_PUNCT0 + 5'd7;
			"@":     return KIND_PUNCT0 + 5'd8;
			"*":     return KIND_PUNCT0 + 5'd9;
			"+":     return KIND_PUNCT0 + 5'd10;
			default: return KIND_IDENT;
		endcase
	endfunction

	function automatic logic is_digit(input logic [7:0] c);
		return c inside {["0":"9"]};
	endfunction

	function automatic logic is_alpha(input logic [7:0] c);
		return c inside {["A":"Z"], ["a":"z"]};
	endfunction

	assign b     = item.char_byte;
	assign eoi   = item.end_of_input || (item.char_byte == CH_NUL);
	assign quote = quote_single_q ? CH_SQUOTE : CH_DQUOTE;
	assign pk    = punct_kind(item.char_byte);

	// Next state and the ordered list of results for the byte in hand.
	always_comb begin
		mode_d         = mode_q;
		quote_single_d = quote_single_q;
		kw_word_d      = kw_word_q;
		kw_pos_d       = kw_pos_q;
		line_d         = line_q;
		col_d          = col_q;
		tok_line_d     = tok_line_q;
		tok_col_d      = tok_col_q;
		res            = '0;
		n              = 2'd0;
		go_idle        = 1'b0;
		do_str         = 1'b0;

		if (eoi) begin
			// Close whatever token is open, then report end of input.
			case (mode_q)
				M_IDENT: begin
					res[n] = make_res(ident_kind(kw_word_q, kw_pos_q), 8'd0, 1'b0, 1'b1,
						tok_line_q, tok_col_q, ERR_NONE);
					n = n + 2'd1;
				end
				M_NUMBER: begin
					res[n] = make_res(KIND_NUMBER, 8'd0, 1'b0, 1'b1, tok_line_q, tok_col_q,
						ERR_NONE);
					n = n + 2'd1;
				end
				M_ESCAPE: begin
					res[n] = make_res(KIND_STRING, CH_BSLASH, 1'b1, 1'b0, tok_line_q,
						tok_col_q, ERR_NONE);
					n = n + 2'd1;
					res[n] = make_res(KIND_STRING, 8'd0, 1'b0, 1'b1, tok_line_q, tok_col_q,
						ERR_UNTERMIN);
					n = n + 2'd1;
				end
				M_STRING: begin
					res[n] = make_res(KIND_STRING, 8'd0, 1'b0, 1'b1, tok_line_q, tok_col_q,
						ERR_UNTERMIN);
					n = n + 2'd1;
				end
				M_PIPE: begin
					res[n] = make_res(KIND_IDENT, CH_BAR, 1'b0, 1'b0, tok_line_q, tok_col_q,
						ERR_UNKNOWN);
					n = n + 2'd1;
				end
				default: begin
				end
			endcase
			res[n] = make_res(KIND_EOF, 8'd0, 1'b0, 1'b1, line_q, col_q, ERR_NONE);
			n = n + 2'd1;
			mode_d    = M_IDLE;
			kw_word_d = KW_NONE;
			kw_pos_d  = 3'd0;
		end else begin
			// Continue or close the open token.
			case (mode_q)
				M_IDENT: begin
					if (is_alpha(b) || is_digit(b) || b == CH_USCORE || b == CH_DASH) begin
						if (kw_next_ok(kw_word_q, kw_pos_q, b)) begin
							kw_pos_d = kw_pos_q + 3'd1;
						end else begin
							kw_word_d = KW_NONE;
							kw_pos_d  = 3'd0;
						end
						res[n] = make_res(KIND_IDENT, b, 1'b1, 1'b0, tok_line_q, tok_col_q,
							ERR_NONE);
						n = n + 2'd1;
					end else begin
						res[n] = make_res(ident_kind(kw_word_q, kw_pos_q), 8'd0, 1'b0, 1'b1,
							tok_line_q, tok_col_q, ERR_NONE);
						n = n + 2'd1;
						kw_word_d = KW_NONE;
						kw_pos_d  = 3'd0;
						go_idle   = 1'b1;
					end
				end
				M_NUMBER: begin
					if (is_digit(b)) begin
						res[n] = make_res(KIND_NUMBER, b, 1'b1, 1'b0, tok_line_q, tok_col_q,
							ERR_NONE);
						n = n + 2'd1;
					end else begin
						res[n] = make_res(KIND_NUMBER, 8'd0, 1'b0, 1'b1, tok_line_q, tok_col_q,
							ERR_NONE);
						n = n + 2'd1;
						go_idle = 1'b1;
					end
				end
				M_STRING: begin
					do_str = 1'b1;
				end
				M_ESCAPE: begin
					if (b == quote) begin
						res[n] = make_res(KIND_STRING, b, 1'b1, 1'b0, tok_line_q, tok_col_q,
							ERR_NONE);
						n = n + 2'd1;
						mode_d = M_STRING;
					end else begin
						res[n] = make_res(KIND_STRING, CH_BSLASH, 1'b1, 1'b0, tok_line_q,
							tok_col_q, ERR_NONE);
						n = n + 2'd1;
						do_str = 1'b1;
					end
				end
				M_PIPE: begin
					if (b == CH_GT) begin
						res[n] = make_res(KIND_PIPE, CH_BAR, 1'b1, 1'b0, tok_line_q, tok_col_q,
							ERR_NONE);
						n = n + 2'd1;
						res[n] = make_res(KIND_PIPE, CH_GT, 1'b1, 1'b0, tok_line_q, tok_col_q,
							ERR_NONE);
						n = n + 2'd1;
						res[n] = make_res(KIND_PIPE, 8'd0, 1'b0, 1'b1, tok_line_q, tok_col_q,
							ERR_NONE);
						n = n + 2'd1;
						mode_d = M_IDLE;
					end else begin
						res[n] = make_res(KIND_IDENT, CH_BAR, 1'b0, 1'b0, tok_line_q, tok_col_q,
							ERR_UNKNOWN);
						n = n + 2'd1;
						go_idle = 1'b1;
					end
				end
				M_COMMENT: begin
					go_idle = (b == CH_NEWLINE);
				end
				default: begin
					go_idle = 1'b1;
				end
			endcase

			// A byte inside a quoted string.
			if (do_str) begin
				if (b == quote) begin
					res[n] = make_res(KIND_STRING, 8'd0, 1'b0, 1'b1, tok_line_q, tok_col_q,
						ERR_NONE);
					n = n + 2'd1;
					mode_d = M_IDLE;
				end else if (b == CH_BSLASH) begin
					mode_d = M_ESCAPE;
				end else begin
					mode_d = M_STRING;
					res[n] = make_res(KIND_STRING, b, 1'b1, 1'b0, tok_line_q, tok_col_q,
						ERR_NONE);
					n = n + 2'd1;
				end
			end

			// A byte seen between tokens, which may open a new one.
			if (go_idle) begin
				mode_d = M_IDLE;
				if (b == CH_SPACE || b inside {[8'd9:8'd13]}) begin
					mode_d = M_IDLE;
				end else if (b == CH_HASH) begin
					mode_d = M_COMMENT;
				end else if (is_alpha(b) || b == CH_USCORE) begin
					tok_line_d = line_q;
					tok_col_d  = col_q;
					mode_d     = M_IDENT;
					kw_pos_d   = 3'd0;
					kw_word_d  = KW_NONE;
					if (b == "T" || b == "F" || b == "N") begin
						kw_pos_d  = 3'd1;
						kw_word_d = (b == "T") ? KW_TRUE : ((b == "F") ? KW_FALSE : KW_NULL);
					end
					res[n] = make_res(KIND_IDENT, b, 1'b1, 1'b0, line_q, col_q, ERR_NONE);
					n = n + 2'd1;
				end else if (b == CH_DQUOTE || b == CH_SQUOTE) begin
					tok_line_d     = line_q;
					tok_col_d      = col_q;
					mode_d         = M_STRING;
					quote_single_d = (b == CH_SQUOTE);
				end else if (is_digit(b)) begin
					tok_line_d = line_q;
					tok_col_d  = col_q;
					mode_d     = M_NUMBER;
					res[n] = make_res(KIND_NUMBER, b, 1'b1, 1'b0, line_q, col_q, ERR_NONE);
					n = n + 2'd1;
				end else if (b == CH_BAR) begin
					tok_line_d = line_q;
					tok_col_d  = col_q;
					mode_d     = M_PIPE;
				end else if (pk != KIND_IDENT) begin
					tok_line_d = line_q;
					tok_col_d  = col_q;
					res[n] = make_res(pk, b, 1'b1, 1'b0, line_q, col_q, ERR_NONE);
					n = n + 2'd1;
					res[n] = make_res(pk, 8'd0, 1'b0, 1'b1, line_q, col_q, ERR_NONE);
					n = n + 2'd1;
				end else begin
					res[n] = make_res(KIND_IDENT, b, 1'b0, 1'b0, line_q, col_q, ERR_UNKNOWN);
					n = n + 2'd1;
				end
			end

			// Saturating position counters.
			if (b == CH_NEWLINE) begin
				if (line_q != '1) begin
					line_d = line_q + POSITION_BITS'(1);
				end
				col_d = POSITION_BITS'(1);
			end else if (col_q != '1) begin
				col_d = col_q + POSITION_BITS'(1);
			end
		end

		// Flag the final result of this transaction.
		if (n != 2'd0) begin
			res[n - 2'd1].last_of_run = 1'b1;
		end
	end

	assign bundle.res   = res;
	assign bundle.count = n;

	// Scanner state advances once per processed byte.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q         <= M_IDLE;
			quote_single_q <= 1'b0;
			kw_word_q      <= KW_NONE;
			kw_pos_q       <= 3'd0;
			line_q         <= POSITION_BITS'(1);
			col_q          <= POSITION_BITS'(1);
			tok_line_q     <= POSITION_BITS'(1);
			tok_col_q      <= POSITION_BITS'(1);
		end else if (fire) begin
			mode_q         <= mode_d;
			quote_single_q <= quote_single_d;
			kw_word_q      <= kw_word_d;
			kw_pos_q       <= kw_pos_d;
			line_q         <= line_d;
			col_q          <= col_d;
			tok_line_q     <= tok_line_d;
			tok_col_q      <= tok_col_d;
		end
	end

	// End of input always yields at least the end-of-file result.
	a_eoi_has_result: assert property (@(posedge clk) disable iff (!arst_n)
		fire && eoi |-> bundle.count != 2'd0)
		else $error("end of input produced no result");

endmodule

@@ rtl/dts_result_queue.sv @@
// Output register plus a two-entry holding buffer that serializes each byte's results.
module dts_result_queue import dts_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        load,
	input  res_bundle_t bundle,
	output logic        can_load,
	dts_stream_if.source token_stream
);

	result_t       out_q;
	logic          out_valid_q;
	result_t [1:0] pend_q;
	logic [1:0]    pend_cnt_q;
	logic          out_free;

	// The output register frees when empty or when its transaction completes.
	assign out_free = !out_valid_q || token_stream.ready;
	assign can_load = (pend_cnt_q == 2'd0) && out_free;

	assign token_stream.valid   = out_valid_q;
	assign token_stream.payload = out_q;

	// Control: output valid and the number of results still held back.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
			pend_cnt_q  <= 2'd0;
		end else if (load) begin
			out_valid_q <= (bundle.count != 2'd0);
			pend_cnt_q  <= (bundle.count != 2'd0) ? bundle.count - 2'd1 : 2'd0;
		end else if (out_free) begin
			out_valid_q <= (pend_cnt_q != 2'd0);
			if (pend_cnt_q != 2'd0) begin
				pend_cnt_q <= pend_cnt_q - 2'd1;
			end
		end
	end

	// Payload: first result goes out at once, the rest shift forward one per transaction.
	always_ff @(posedge clk) begin
		if (load) begin
			out_q     <= bundle.res[0];
			pend_q[0] <= bundle.res[1];
			pend_q[1] <= bundle.res[2];
		end else if (out_free && pend_cnt_q != 2'd0) begin
			out_q     <= pend_q[0];
			pend_q[0] <= pend_q[1];
		end
	end

	a_pend_shown: assert property (@(posedge clk) disable iff (!arst_n)
		pend_cnt_q != 2'd0 |-> out_valid_q)
		else $error("held results without a result on the output");

	a_load_shows: assert property (@(posedge clk) disable iff (!arst_n)
		load && bundle.count != 2'd0 |=> out_valid_q && pend_cnt_q == $past(bundle.count) - 2'd1)
		else $error("loaded results not presented");

	a_drain_step: assert property (@(posedge clk) disable iff (!arst_n)
		pend_cnt_q == 2'd2 |=> pend_cnt_q != 2'd0)
		else $error("holding buffer dropped more than one result");

endmodule

@@ rtl/dsl_token_scanner_top.sv @@
// Top level of the DSL token scanner: input register, scanner core and result queue.
//
//  channel       | dir | payload        | notes
//  --------------+-----+----------------+-------------------------------------------
//  char_stream   | in  | in_item_t      | one text byte (or end of input) per transaction
//  token_stream  | out | result_t       | one content byte, marker or error per transaction
//
//  A byte is taken every cycle as long as it causes at most one result and the output
//  is not stalled; a byte that causes more results holds the input while the single output
//  register drains the holding buffer. A byte passes the input register, then the output register.
//  Reset clears the scan mode and sets all line and column counters to 1; no memory
//  needs clearing. A stalled output fills the output register, then the input register,
//  then drops char_stream.ready.
module dsl_token_scanner_top import dts_pkg::*; #(
	parameter int unsigned POSITION_BITS = POSITION_BITS_DEFAULT
) (
	input logic clk,
	input logic arst_n,
	dts_stream_if.sink   char_stream,
	dts_stream_if.source token_stream
);

	logic        valid_s1;
	in_item_t    item_s1;
	logic        can_load;
	logic        fire;
	res_bundle_t bundle;

	// The registered byte is processed once the queue can take all its results.
	assign fire              = valid_s1 && can_load;
	assign char_stream.ready = !valid_s1 || can_load;

	// Input register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (char_stream.ready) begin
			valid_s1 <= char_stream.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (char_stream.ready && char_stream.valid) begin
			item_s1 <= char_stream.payload;
		end
	end

	dts_scan_core #(
		.POSITION_BITS(POSITION_BITS)
	) u_core (
		.clk    (clk),
		.arst_n (arst_n),
		.fire   (fire),
		.item   (item_s1),
		.bundle (bundle)
	);

	dts_result_queue u_queue (
		.clk          (clk),
		.arst_n       (arst_n),
		.load         (fire),
		.bundle       (bundle),
		.can_load     (can_load),
		.token_stream (token_stream)
	);

endmodule
